>>> sv/cvm_pkg.sv
// ----------------------------------------------------------------------------
// cvm_pkg
// Types, register codes and small arithmetic helpers for the closest video
// mode search.
// ----------------------------------------------------------------------------
package cvm_pkg;

  localparam int COLOR_W   = 5;
  localparam int DIM_W     = 14;
  localparam int RATE_W    = 10;
  localparam int WCOLOR_W  = 6;
  localparam int WRATE_W   = 11;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CKEY_W    = 6;
  localparam int SKEY_W    = 29;
  localparam int RKEY_W    = 12;
  localparam int INDEX_W   = 8;

  localparam logic [CKEY_W-1:0]   COLOR_SAT      = 6'd63;
  localparam logic [WCOLOR_W-1:0] WANT_DONT_CARE = 6'h3F;
  localparam logic [WRATE_W-1:0]  WANT_HIGHEST   = 11'h7FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WANT_RED     = 3'd0,
    REG_WANT_GREEN   = 3'd1,
    REG_WANT_BLUE    = 3'd2,
    REG_WANT_WIDTH   = 3'd3,
    REG_WANT_HEIGHT  = 3'd4,
    REG_WANT_REFRESH = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [WCOLOR_W-1:0] red;
    logic [WCOLOR_W-1:0] green;
    logic [WCOLOR_W-1:0] blue;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [WRATE_W-1:0]  refresh;
  } want_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [RATE_W-1:0]  refresh;
  } mode_t;

  typedef struct packed {
    logic [CKEY_W-1:0] color;
    logic [SKEY_W-1:0] size;
    logic [RKEY_W-1:0] rate;
  } key_t;

  // |cand - want| with want a signed 6-bit value, cand unsigned 5-bit
  function automatic logic [CKEY_W-1:0] color_dist(logic [COLOR_W-1:0] c,
                                                   logic [WCOLOR_W-1:0] w);
    logic [WCOLOR_W:0] d;
    logic [WCOLOR_W:0] n;
    d = {2'b00, c} - {w[WCOLOR_W-1], w};
    n = -d;
    return d[WCOLOR_W] ? n[CKEY_W-1:0] : d[CKEY_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] dim_dist(logic [DIM_W-1:0] c,
                                                logic [DIM_W-1:0] w);
    logic [DIM_W:0] d;
    logic [DIM_W:0] n;
    d = {1'b0, c} - {1'b0, w};
    n = -d;
    return d[DIM_W] ? n[DIM_W-1:0] : d[DIM_W-1:0];
  endfunction

  // rate key: plain distance below 2048; prefer-highest maps above all of them
  function automatic logic [RKEY_W-1:0] rate_key(logic [RATE_W-1:0] c,
                                                 logic [WRATE_W-1:0] w);
    logic [RKEY_W-1:0] d;
    logic [RKEY_W-1:0] n;
    d = {2'b00, c} - {w[WRATE_W-1], w};
    n = -d;
    if (w == WANT_HIGHEST) begin
      return {2'b10, ~c};
    end
    return d[RKEY_W-1] ? n : d;
  endfunction

endpackage

>>> sv/cvm_key_calc.sv
// ----------------------------------------------------------------------------
// cvm_key_calc
// Input register and key stage: colour, size and rate distances per request.
// ----------------------------------------------------------------------------
module cvm_key_calc (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cvm_pkg::mode_t in_mode,
  input  logic          in_final,
  input  cvm_pkg::want_t want,
  output logic          k_valid,
  input  logic          k_ready,
  output cvm_pkg::key_t  k_key,
  output cvm_pkg::mode_t k_mode,
  output logic          k_final
);
  import cvm_pkg::*;

  logic  v1;
  logic  v1_next;
  mode_t mode1;
  logic  final1;
  logic  v2_next;
  logic  s2_free;
  logic  move1;
  logic  in_fire;

  logic [CKEY_W:0]     dr;
  logic [CKEY_W:0]     dg;
  logic [CKEY_W:0]     db;
  logic [CKEY_W+1:0]   csum;
  logic [DIM_W-1:0]    dw;
  logic [DIM_W-1:0]    dh;
  logic [2*DIM_W-1:0]  sqw;
  logic [2*DIM_W-1:0]  sqh;
  key_t                key_next;

  assign s2_free  = !k_valid || k_ready;
  assign move1    = v1 && s2_free;
  assign in_ready = !v1 || s2_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    dr = (want.red   == WANT_DONT_CARE) ? '0 : {1'b0, color_dist(mode1.red,   want.red)};
    dg = (want.green == WANT_DONT_CARE) ? '0 : {1'b0, color_dist(mode1.green, want.green)};
    db = (want.blue  == WANT_DONT_CARE) ? '0 : {1'b0, color_dist(mode1.blue,  want.blue)};
    csum = {1'b0, dr} + {1'b0, dg} + {1'b0, db};
    dw  = dim_dist(mode1.width,  want.width);
    dh  = dim_dist(mode1.height, want.height);
    sqw = dw * dw;
    sqh = dh * dh;
    key_next.color = (csum > {2'b00, COLOR_SAT}) ? COLOR_SAT : csum[CKEY_W-1:0];
    key_next.size  = {1'b0, sqw} + {1'b0, sqh};
    key_next.rate  = rate_key(mode1.refresh, want.refresh);
  end

  always_comb begin
    v1_next = v1;
    if (in_fire) begin
      v1_next = 1'b1;
    end else if (move1) begin
      v1_next = 1'b0;
    end
    v2_next = k_valid;
    if (move1) begin
      v2_next = 1'b1;
    end else if (k_ready) begin
      v2_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      k_valid <= 1'b0;
    end else begin
      v1      <= v1_next;
      k_valid <= v2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode1  <= in_mode;
      final1 <= in_final;
    end
    if (move1) begin
      k_key   <= key_next;
      k_mode  <= mode1;
      k_final <= final1;
    end
  end

endmodule

>>> sv/cvm_best_track.sv
// ----------------------------------------------------------------------------
// cvm_best_track
// Running best compare and update, candidate counter and result register.
// ----------------------------------------------------------------------------
module cvm_best_track #(
  parameter int MAX_MODES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           k_valid,
  output logic                           k_ready,
  input  cvm_pkg::key_t                  k_key,
  input  cvm_pkg::mode_t                 k_mode,
  input  logic                           k_final,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cvm_pkg::INDEX_W-1:0]    best_index,
  output cvm_pkg::mode_t                 best_mode
);
  import cvm_pkg::*;

  localparam int CW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] LAST_COUNT = CW'(MAX_MODES - 1);

  logic          have_choice;
  logic [CW-1:0] cand_counter;
  key_t          least;
  logic [CW-1:0] chosen_index;
  mode_t         chosen_mode;

  logic          fire;
  logic          better;
  logic          out_valid_next;
  logic [CW-1:0] pick_index;
  mode_t         pick_mode;
  logic [IW-1:0] pick_index_ext;

  assign k_ready = !k_final || !out_valid || out_ready;
  assign fire    = k_valid && k_ready;

  always_comb begin
    better = !have_choice ||
             (k_key.color < least.color) ||
             (k_key.color == least.color && k_key.size < least.size) ||
             (k_key.color == least.color && k_key.size == least.size &&
              k_key.rate < least.rate);
    pick_index     = better ? cand_counter : chosen_index;
    pick_mode      = better ? k_mode : chosen_mode;
    pick_index_ext = IW'(pick_index);
    out_valid_next = out_valid && !out_ready;
    if (fire && k_final) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_choice  <= 1'b0;
      cand_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (fire) begin
        have_choice  <= !k_final;
        cand_counter <= (k_final || cand_counter == LAST_COUNT) ? '0 : cand_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && better) begin
      least        <= k_key;
      chosen_index <= cand_counter;
      chosen_mode  <= k_mode;
    end
    if (fire && k_final) begin
      best_index <= pick_index_ext[INDEX_W-1:0];
      best_mode  <= pick_mode;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    fire && k_final |=> !have_choice && cand_counter == '0)
    else $error("search state not cleared after final candidate");

  a_choice_after_cand: assert property (@(posedge clk) disable iff (rst)
    fire && !k_final |=> have_choice)
    else $error("no choice held after a candidate");

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire && k_final))
    else $error("result raised without a final candidate");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !fire || !k_final)
    else $error("final candidate retired over a pending result");
`endif

endmodule

>>> sv/closest_video_mode_select_unit.sv
// ----------------------------------------------------------------------------
// closest_video_mode_select_unit
// Picks the candidate display mode closest to a configured desired mode.
// ----------------------------------------------------------------------------
// usage:
//   program the desired mode through cfg_we/cfg_index/cfg_data while idle,
//   then stream candidates on in_valid/in_ready, one request per mode, with
//   final_cand set on the last one of the list.
//   each list yields one result on out_valid/out_ready: the index of the
//   winning candidate within the list and its fields.
//   ranking is colour distance, then squared size distance, then refresh
//   distance (highest first for -1); on a tie the earlier candidate stays.
// timing:
//   one candidate per cycle sustained while no final candidate waits on a
//   held result, limited by the compare-and-update loop on the running best.
//   the result shows on out_valid once the final candidate has passed the
//   input register, the key register, then the result register.
// reset:
//   desired colours and refresh go to -1, width and height to 0, search
//   state and counter clear, no result pending.
// stalls:
//   a held result blocks only the next final candidate; other candidates
//   keep flowing, and backpressure reaches in_ready through the pipeline.
// ----------------------------------------------------------------------------
module closest_video_mode_select_unit #(
  parameter int MAX_MODES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cvm_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cvm_pkg::COLOR_W-1:0]     cand_red_bits,
  input  logic [cvm_pkg::COLOR_W-1:0]     cand_green_bits,
  input  logic [cvm_pkg::COLOR_W-1:0]     cand_blue_bits,
  input  logic [cvm_pkg::DIM_W-1:0]       cand_width,
  input  logic [cvm_pkg::DIM_W-1:0]       cand_height,
  input  logic [cvm_pkg::RATE_W-1:0]      cand_refresh,
  input  logic                            final_cand,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cvm_pkg::INDEX_W-1:0]     best_index,
  output logic [cvm_pkg::COLOR_W-1:0]     best_red_bits,
  output logic [cvm_pkg::COLOR_W-1:0]     best_green_bits,
  output logic [cvm_pkg::COLOR_W-1:0]     best_blue_bits,
  output logic [cvm_pkg::DIM_W-1:0]       best_width,
  output logic [cvm_pkg::DIM_W-1:0]       best_height,
  output logic [cvm_pkg::RATE_W-1:0]      best_refresh
);
  import cvm_pkg::*;

  want_t want;
  mode_t in_mode;
  key_t  k_key;
  mode_t k_mode;
  mode_t best_mode;
  logic  k_valid;
  logic  k_ready;
  logic  k_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      want.red     <= WANT_DONT_CARE;
      want.green   <= WANT_DONT_CARE;
      want.blue    <= WANT_DONT_CARE;
      want.width   <= '0;
      want.height  <= '0;
      want.refresh <= WANT_HIGHEST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WANT_RED:     want.red     <= cfg_data[WCOLOR_W-1:0];
        REG_WANT_GREEN:   want.green   <= cfg_data[WCOLOR_W-1:0];
        REG_WANT_BLUE:    want.blue    <= cfg_data[WCOLOR_W-1:0];
        REG_WANT_WIDTH:   want.width   <= cfg_data[DIM_W-1:0];
        REG_WANT_HEIGHT:  want.height  <= cfg_data[DIM_W-1:0];
        REG_WANT_REFRESH: want.refresh <= cfg_data[WRATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_mode.red     = cand_red_bits;
  assign in_mode.green   = cand_green_bits;
  assign in_mode.blue    = cand_blue_bits;
  assign in_mode.width   = cand_width;
  assign in_mode.height  = cand_height;
  assign in_mode.refresh = cand_refresh;

  cvm_key_calc u_key_calc (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .in_final (final_cand),
    .want     (want),
    .k_valid  (k_valid),
    .k_ready  (k_ready),
    .k_key    (k_key),
    .k_mode   (k_mode),
    .k_final  (k_final)
  );

  cvm_best_track #(
    .MAX_MODES (MAX_MODES)
  ) u_best_track (
    .clk        (clk),
    .rst        (rst),
    .k_valid    (k_valid),
    .k_ready    (k_ready),
    .k_key      (k_key),
    .k_mode     (k_mode),
    .k_final    (k_final),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .best_index (best_index),
    .best_mode  (best_mode)
  );

  assign best_red_bits   = best_mode.red;
  assign best_green_bits = best_mode.green;
  assign best_blue_bits  = best_mode.blue;
  assign best_width      = best_mode.width;
  assign best_height     = best_mode.height;
  assign best_refresh    = best_mode.refresh;

endmodule

>>> sim/closest_video_mode_select_checker.sv
// ----------------------------------------------------------------------------
// closest_video_mode_select_checker
// Watches the config port and both streams of the closest video mode search,
// keeps its own running-best search per list and compares every result
// against the oldest predicted winner, field by field.
// ----------------------------------------------------------------------------
module closest_video_mode_select_checker #(
  parameter int MAX_MODES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cvm_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [cvm_pkg::COLOR_W-1:0]     cand_red_bits,
  input  logic [cvm_pkg::COLOR_W-1:0]     cand_green_bits,
  input  logic [cvm_pkg::COLOR_W-1:0]     cand_blue_bits,
  input  logic [cvm_pkg::DIM_W-1:0]       cand_width,
  input  logic [cvm_pkg::DIM_W-1:0]       cand_height,
  input  logic [cvm_pkg::RATE_W-1:0]      cand_refresh,
  input  logic                            final_cand,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [cvm_pkg::INDEX_W-1:0]     best_index,
  input  logic [cvm_pkg::COLOR_W-1:0]     best_red_bits,
  input  logic [cvm_pkg::COLOR_W-1:0]     best_green_bits,
  input  logic [cvm_pkg::COLOR_W-1:0]     best_blue_bits,
  input  logic [cvm_pkg::DIM_W-1:0]       best_width,
  input  logic [cvm_pkg::DIM_W-1:0]       best_height,
  input  logic [cvm_pkg::RATE_W-1:0]      best_refresh,
  output int                              fail_count,
  output int                              pending
);
  import cvm_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    mode_t              mode;
  } pick_t;

  want_t       want;
  bit          have_choice;
  int          cand_count;
  int          best_color;
  logic [31:0] best_size;
  logic [31:0] best_rate;
  int          best_pos;
  mode_t       best_mode;
  pick_t       expected_picks[$];

  function automatic int color_gap(logic [COLOR_W-1:0] c, logic [WCOLOR_W-1:0] w);
    int d;
    d = int'(c) - int'($signed(w));
    return (d < 0) ? -d : d;
  endfunction

  task automatic clear_search();
    have_choice = 1'b0;
    cand_count  = 0;
    best_color  = 0;
    best_size   = '0;
    best_rate   = '0;
    best_pos    = 0;
    best_mode   = '0;
  endtask

  task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_WANT_RED:     want.red     = data[WCOLOR_W-1:0];
      REG_WANT_GREEN:   want.green   = data[WCOLOR_W-1:0];
      REG_WANT_BLUE:    want.blue    = data[WCOLOR_W-1:0];
      REG_WANT_WIDTH:   want.width   = data[DIM_W-1:0];
      REG_WANT_HEIGHT:  want.height  = data[DIM_W-1:0];
      REG_WANT_REFRESH: want.refresh = data[WRATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic rank_candidate(mode_t m, logic last);
    int          color;
    int          dw;
    int          dh;
    int          dr;
    logic [31:0] size_key;
    logic [31:0] rate_key;
    bit          better;
    pick_t       pick;
    color = 0;
    if (want.red != WANT_DONT_CARE) color += color_gap(m.red, want.red);
    if (want.green != WANT_DONT_CARE) color += color_gap(m.green, want.green);
    if (want.blue != WANT_DONT_CARE) color += color_gap(m.blue, want.blue);
    if (color > int'(COLOR_SAT)) color = int'(COLOR_SAT);
    dw = int'(m.width) - int'(want.width);
    dh = int'(m.height) - int'(want.height);
    size_key = dw * dw + dh * dh;
    if (want.refresh == WANT_HIGHEST) begin
      // prefer highest: all-ones minus the rate ranks the fastest first
      rate_key = 32'hFFFF_FFFF - 32'(m.refresh);
    end else begin
      dr = int'(m.refresh) - int'($signed(want.refresh));
      rate_key = (dr < 0) ? -dr : dr;
    end
    better = !have_choice || color < best_color ||
             (color == best_color && size_key < best_size) ||
             (color == best_color && size_key == best_size && rate_key < best_rate);
    if (better) begin
      have_choice = 1'b1;
      best_color  = color;
      best_size   = size_key;
      best_rate   = rate_key;
      best_pos    = cand_count;
      best_mode   = m;
    end
    cand_count = (cand_count + 1) % MAX_MODES;
    if (last) begin
      pick.index = best_pos[INDEX_W-1:0];
      pick.mode  = best_mode;
      expected_picks.push_back(pick);
      clear_search();
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("mismatch on %s: expected %0d, got %0d", name, exp_val, act_val);
      end
    end
  endtask

  task automatic check_result();
    pick_t pick;
    if (expected_picks.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("unexpected result: index %0d with no list pending", best_index);
      end
    end else begin
      pick = expected_picks.pop_front();
      check_field("best_index", 32'(pick.index), 32'(best_index));
      check_field("best_red_bits", 32'(pick.mode.red), 32'(best_red_bits));
      check_field("best_green_bits", 32'(pick.mode.green), 32'(best_green_bits));
      check_field("best_blue_bits", 32'(pick.mode.blue), 32'(best_blue_bits));
      check_field("best_width", 32'(pick.mode.width), 32'(best_width));
      check_field("best_height", 32'(pick.mode.height), 32'(best_height));
      check_field("best_refresh", 32'(pick.mode.refresh), 32'(best_refresh));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      want.red     = WANT_DONT_CARE;
      want.green   = WANT_DONT_CARE;
      want.blue    = WANT_DONT_CARE;
      want.width   = '0;
      want.height  = '0;
      want.refresh = WANT_HIGHEST;
      clear_search();
      expected_picks.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      // a result can never belong to the request taken at the same edge
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        rank_candidate('{red: cand_red_bits, green: cand_green_bits,
                         blue: cand_blue_bits, width: cand_width,
                         height: cand_height, refresh: cand_refresh},
                       final_cand);
      end
    end
    pending = expected_picks.size();
  end

endmodule

>>> sim/closest_video_mode_select_unit_tb.sv
// ----------------------------------------------------------------------------
// closest_video_mode_select_unit_tb
// Drives candidate lists into the closest video mode search under a range of
// desired-mode settings, with random gaps on both streams and one long output
//   stall, and bases the verdict on checker failures and pending results.
// ----------------------------------------------------------------------------
module closest_video_mode_select_unit_tb;
  import cvm_pkg::*;

  localparam int MAX_MODES    = 256;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_TARGET  = 830;
  localparam int HOLD_CYCLES  = 300;
  localparam int LONG_LIST    = 300;
  localparam int LONG_WINNER  = 270;

  // indexes past the register list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COLOR_W-1:0]   cand_red_bits = '0;
  logic [COLOR_W-1:0]   cand_green_bits = '0;
  logic [COLOR_W-1:0]   cand_blue_bits = '0;
  logic [DIM_W-1:0]     cand_width = '0;
  logic [DIM_W-1:0]     cand_height = '0;
  logic [RATE_W-1:0]    cand_refresh = '0;
  logic                 final_cand = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [INDEX_W-1:0]   best_index;
  logic [COLOR_W-1:0]   best_red_bits;
  logic [COLOR_W-1:0]   best_green_bits;
  logic [COLOR_W-1:0]   best_blue_bits;
  logic [DIM_W-1:0]     best_width;
  logic [DIM_W-1:0]     best_height;
  logic [RATE_W-1:0]    best_refresh;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent_count = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  closest_video_mode_select_unit #(.MAX_MODES(MAX_MODES)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cand_red_bits(cand_red_bits), .cand_green_bits(cand_green_bits),
    .cand_blue_bits(cand_blue_bits), .cand_width(cand_width),
    .cand_height(cand_height), .cand_refresh(cand_refresh),
    .final_cand(final_cand),
    .out_valid(out_valid), .out_ready(out_ready),
    .best_index(best_index), .best_red_bits(best_red_bits),
    .best_green_bits(best_green_bits), .best_blue_bits(best_blue_bits),
    .best_width(best_width), .best_height(best_height),
    .best_refresh(best_refresh)
  );

  closest_video_mode_select_checker #(.MAX_MODES(MAX_MODES)) i_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cand_red_bits(cand_red_bits), .cand_green_bits(cand_green_bits),
    .cand_blue_bits(cand_blue_bits), .cand_width(cand_width),
    .cand_height(cand_height), .cand_refresh(cand_refresh),
    .final_cand(final_cand),
    .out_valid(out_valid), .out_ready(out_ready),
    .best_index(best_index), .best_red_bits(best_red_bits),
    .best_green_bits(best_green_bits), .best_blue_bits(best_blue_bits),
    .best_width(best_width), .best_height(best_height),
    .best_refresh(best_refresh),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL closest_video_mode_select_unit");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic mode_t mk(int r, int g, int b, int w, int h, int f);
    mode_t m;
    m.red     = r[COLOR_W-1:0];
    m.green   = g[COLOR_W-1:0];
    m.blue    = b[COLOR_W-1:0];
    m.width   = w[DIM_W-1:0];
    m.height  = h[DIM_W-1:0];
    m.refresh = f[RATE_W-1:0];
    return m;
  endfunction

  // wild draws cover the full field widths, tame ones stay in usual ranges
  function automatic mode_t random_mode(bit wild);
    mode_t m;
    m.red     = COLOR_W'(wild ? $urandom_range(0, 31) : $urandom_range(0, 16));
    m.green   = COLOR_W'(wild ? $urandom_range(0, 31) : $urandom_range(0, 16));
    m.blue    = COLOR_W'(wild ? $urandom_range(0, 31) : $urandom_range(0, 16));
    m.width   = DIM_W'(wild ? $urandom_range(0, 16383) : $urandom_range(0, 2048));
    m.height  = DIM_W'(wild ? $urandom_range(0, 16383) : $urandom_range(0, 2048));
    m.refresh = RATE_W'($urandom_range(0, 1023));
    return m;
  endfunction

  // nudge at most one field so that the other keys tie with the base
  function automatic mode_t vary_mode(mode_t base);
    mode_t m;
    m = base;
    case ($urandom_range(0, 6))
      0: m.red     = COLOR_W'(base.red + $urandom_range(0, 2) - 1);
      1: m.green   = COLOR_W'(base.green + $urandom_range(0, 2) - 1);
      2: m.blue    = COLOR_W'(base.blue + $urandom_range(0, 2) - 1);
      3: m.width   = DIM_W'(base.width + $urandom_range(0, 2) - 1);
      4: m.height  = DIM_W'(base.height + $urandom_range(0, 2) - 1);
      5: m.refresh = RATE_W'(base.refresh + $urandom_range(0, 2) - 1);
      default: ;
    endcase
    return m;
  endfunction

  function automatic logic [CFG_W-1:0] want_color_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return {8'($urandom), WANT_DONT_CARE};
    if (r < 80) return CFG_W'($urandom_range(0, 16));
    return CFG_W'($urandom_range(0, 16383));
  endfunction

  function automatic logic [CFG_W-1:0] want_dim_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return 14'h3FFF;
    if (r < 75) return CFG_W'($urandom_range(0, 2048));
    return CFG_W'($urandom_range(0, 16383));
  endfunction

  function automatic logic [CFG_W-1:0] want_rate_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return {3'($urandom), WANT_HIGHEST};
    if (r < 85) return CFG_W'($urandom_range(0, 1023));
    return CFG_W'($urandom_range(0, 16383));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_want(logic [CFG_W-1:0] r, logic [CFG_W-1:0] g,
                              logic [CFG_W-1:0] b, logic [CFG_W-1:0] w,
                              logic [CFG_W-1:0] h, logic [CFG_W-1:0] f);
    write_reg(REG_WANT_RED, r);
    write_reg(REG_WANT_GREEN, g);
    write_reg(REG_WANT_BLUE, b);
    write_reg(REG_WANT_WIDTH, w);
    write_reg(REG_WANT_HEIGHT, h);
    write_reg(REG_WANT_REFRESH, f);
    write_reg(REG_SPARE_LO, CFG_W'($urandom_range(0, 16383)));
    write_reg(REG_SPARE_HI, CFG_W'($urandom_range(0, 16383)));
    cfg_we <= 1'b0;
  endtask

  task automatic send_cand(mode_t m, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    cand_red_bits   <= m.red;
    cand_green_bits <= m.green;
    cand_blue_bits  <= m.blue;
    cand_width      <= m.width;
    cand_height     <= m.height;
    cand_refresh    <= m.refresh;
    final_cand      <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_list(int len);
    mode_t base;
    mode_t m;
    int    r;
    base = random_mode($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) m = vary_mode(base);
      else if (r < 85) m = random_mode(1'b0);
      else m = random_mode(1'b1);
      send_cand(m, i == len - 1);
    end
  endtask

  // settle: every expected result in, then drain the pipeline
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // output side: random ready bursts, one long hold-off on request
  initial begin
    int burst;
    int gap;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= 1'b1;
      burst = $urandom_range(1, 16);
      repeat (burst) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int    phase;
    int    lists;
    mode_t m;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset setting: colours ignored, size 0x0, fastest refresh preferred
    send_cand(mk(31, 31, 31, 16383, 16383, 1023), 1'b1);
    send_cand(mk(8, 8, 8, 100, 100, 60), 1'b0);
    send_cand(mk(8, 8, 8, 100, 100, 60), 1'b0);
    send_cand(mk(16, 0, 16, 100, 100, 144), 1'b0);
    send_cand(mk(0, 16, 0, 100, 100, 143), 1'b1);
    wait_idle();

    // green ignored through a wide pattern whose low bits are all ones
    program_want(14'd16, 14'h3FFF, 14'd0, 14'h3FFF, 14'd0, 14'd1023);
    send_cand(mk(16, 5, 0, 16383, 0, 1000), 1'b0);
    send_cand(mk(15, 31, 1, 16383, 0, 1023), 1'b0);
    send_cand(mk(16, 0, 0, 16380, 0, 1023), 1'b0);
    send_cand(mk(16, 9, 0, 16383, 0, 1023), 1'b1);
    wait_idle();

    // most negative red and refresh wants, colour sum saturates, blue near -1 only
    program_want(14'h0020, 14'h001F, 14'h3FFE, 14'd0, 14'h3FFF, 14'h0400);
    send_cand(mk(31, 0, 31, 0, 16383, 0), 1'b0);
    send_cand(mk(0, 31, 0, 0, 16383, 0), 1'b0);
    send_cand(mk(31, 31, 31, 0, 0, 1023), 1'b0);
    send_cand(mk(0, 31, 0, 0, 16383, 1023), 1'b1);
    wait_idle();

    program_want(14'h3F, 14'h3F, 14'h3F, 14'd8191, 14'd8191, 14'h07FE);
    send_cand(mk(0, 0, 0, 0, 0, 0), 1'b0);
    send_cand(mk(31, 31, 31, 16383, 16383, 1023), 1'b0);
    send_cand(mk(5, 5, 5, 8191, 8191, 0), 1'b0);
    send_cand(mk(1, 2, 3, 8191, 8191, 0), 1'b0);
    send_cand(mk(0, 0, 0, 8190, 8192, 1023), 1'b1);
    wait_idle();

    phase = 0;
    while (sent_count < ITEM_TARGET) begin
      if (phase == 4) begin
        // list longer than the counter: winner sits past the wrap
        program_want(14'h3F, 14'h3F, 14'h3F, 14'd0, 14'd0, 14'h7FF);
        for (int i = 0; i < LONG_LIST; i++) begin
          m = random_mode(1'b0);
          m.width  = (i == LONG_WINNER) ? 14'd3 : 14'($urandom_range(100, 16383));
          m.height = (i == LONG_WINNER) ? 14'd3 : 14'($urandom_range(100, 16383));
          send_cand(m, i == LONG_LIST - 1);
        end
      end else begin
        program_want(want_color_data(), want_color_data(), want_color_data(),
                     want_dim_data(), want_dim_data(), want_rate_data());
        no_idle = (phase == 2);
        if (phase == 1) begin
          // short lists keep finals coming while the output is held off
          hold_req = 1'b1;
          repeat (40) send_list($urandom_range(1, 3));
        end else begin
          lists = $urandom_range(4, 10);
          repeat (lists) begin
            if ($urandom_range(0, 9) == 0) send_list($urandom_range(9, 40));
            else send_list($urandom_range(1, 8));
          end
        end
      end
      wait_idle();
      no_idle = 1'b0;
      phase++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS closest_video_mode_select_unit");
    end else begin
      $display("FAIL closest_video_mode_select_unit");
    end
    $finish;
  end

endmodule
